FILE: rtl/core/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg
// Shared constants and types of the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

    localparam int unsigned SMP_W     = 32;
    localparam int unsigned RATIO_W   = 31;
    localparam int unsigned FRAC_W    = 28;
    // hard ceiling on results per input, whatever the run parameter says
    localparam int unsigned OUT_LIMIT = 8;

    localparam logic [SMP_W-1:0] FIX_ONE   = 32'h1000_0000;
    localparam logic [SMP_W-1:0] SNAP_ADD  = 32'h0000_0080;
    localparam logic [SMP_W-1:0] SNAP_TEST = 32'h0fff_ff00;
    localparam logic [SMP_W-1:0] FRAC_MASK = 32'h0fff_ffff;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ADD  = 4'b0100,
        ST_OUT  = 4'b1000
    } seq_state_t;

endpackage

FILE: rtl/core/lir_ifs.sv
// ----------------------------------------------------------------------------
// lir_ifs
// Valid/ready channels for input samples and interpolated results.
// ----------------------------------------------------------------------------
interface lir_smp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface lir_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_out;
    logic               run_end;

    modport source (output valid, output sample_out, output run_end, input ready);
    modport sink   (input valid, input sample_out, input run_end, output ready);
endinterface

FILE: rtl/core/lir_mul.sv
// ----------------------------------------------------------------------------
// lir_mul
// Registered signed 32x32 multiply, result scaled down by the 4.28 fraction.
// ----------------------------------------------------------------------------
module lir_mul (
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [lir_pkg::SMP_W-1:0] a,
    input  logic signed [lir_pkg::SMP_W-1:0] b,
    output logic        [lir_pkg::SMP_W-1:0] prod
);

    logic signed [2*lir_pkg::SMP_W-1:0] full;
    logic        [lir_pkg::SMP_W-1:0]   prod_reg;

    assign full = a * b;

    // arithmetic shift by the fraction width, keep the low word
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= full[lir_pkg::FRAC_W +: lir_pkg::SMP_W];
        end
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/core/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Linear interpolation sample rate converter, one channel, signed 4.28.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch carries one input sample per request; result_ch carries the
//   interpolated samples, run_end marking the last result of an input.
//   cfg_we/cfg_data write rate_ratio (input rate over output rate, unsigned 3.28);
//   write it only while the block is idle.
//   Each result passes through the shared multiplier loop (multiply, add
//   and position update, hand over); up to MAX_RUN (at most 8) results per
//   input. A ratio of one passes the sample straight through. The first
//   sample taken after reset at a ratio other than one, and a sample whose
//   position is already at or past one, are absorbed with no result.
//   sample_ch.ready is high only when the sequencer is idle.
//   A stalled result holds in the output register; the sequencer waits.
//   Reset clears the history, the position and restores the ratio to one.
// ----------------------------------------------------------------------------
module linear_interp_resampler #(
    parameter int unsigned MAX_RUN = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    lir_smp_if.sink                        sample_ch,
    lir_res_if.source                      result_ch,
    input  logic                           cfg_we,
    input  logic [lir_pkg::RATIO_W-1:0]    cfg_data
);

    localparam int unsigned RUN_LIMIT =
        (MAX_RUN < lir_pkg::OUT_LIMIT) ? MAX_RUN : lir_pkg::OUT_LIMIT;
    localparam int unsigned CNT_W = $clog2(RUN_LIMIT + 1);

    localparam int unsigned W = lir_pkg::SMP_W;

    lir_pkg::seq_state_t state_reg, state_next;

    logic [lir_pkg::RATIO_W-1:0] ratio_reg, ratio_next;
    logic [W-1:0]                prev_reg, prev_next;
    logic [W-1:0]                pos_reg, pos_next;
    logic                        primed_reg, primed_next;
    logic [W-1:0]                cur_reg, cur_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        pass_reg, pass_next;
    logic                        out_valid_reg, out_valid_next;
    logic [W-1:0]                out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;

    logic [W-1:0]     diff;
    logic [W-1:0]     prod;
    logic [W-1:0]     interp;
    logic [W-1:0]     pos_add;
    logic [W-1:0]     snap_sum;
    logic [W-1:0]     pos_snap;
    logic [CNT_W-1:0] cnt_inc;
    logic             run_last;
    logic             pos_below_one;
    logic             is_passthrough;
    logic             in_acc;

    assign diff = cur_reg - prev_reg;

    lir_mul u_mul (
        .clk  (clk),
        .en   (state_reg == lir_pkg::ST_MUL),
        .a    (diff),
        .b    (pos_reg),
        .prod (prod)
    );

    assign interp   = (pos_reg == '0) ? prev_reg : (prev_reg + prod);
    assign pos_add  = pos_reg + {1'b0, ratio_reg};
    assign snap_sum = pos_add + lir_pkg::SNAP_ADD;
    // snap to the integer when within 0x80 of it
    assign pos_snap = ((snap_sum & lir_pkg::SNAP_TEST) == '0) ?
                      (snap_sum & ~lir_pkg::FRAC_MASK) : pos_add;
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign run_last = (cnt_inc == CNT_W'(RUN_LIMIT)) ||
                      !($signed(pos_snap) < $signed(lir_pkg::FIX_ONE));

    assign pos_below_one  = $signed(pos_reg) < $signed(lir_pkg::FIX_ONE);
    assign is_passthrough = (ratio_reg == lir_pkg::FIX_ONE[lir_pkg::RATIO_W-1:0]);

    assign sample_ch.ready = (state_reg == lir_pkg::ST_IDLE);
    assign in_acc          = sample_ch.valid && sample_ch.ready;

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.sample_out = out_data_reg;
    assign result_ch.run_end    = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        ratio_next     = ratio_reg;
        prev_next      = prev_reg;
        pos_next       = pos_reg;
        primed_next    = primed_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (cfg_we)
        begin
            ratio_next = cfg_data;
        end

        case (state_reg)
            lir_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (is_passthrough)
                    begin
                        out_data_next  = sample_ch.sample_in;
                        out_last_next  = 1'b1;
                        out_valid_next = 1'b1;
                        pass_next      = 1'b1;
                        state_next     = lir_pkg::ST_OUT;
                    end
                    else if (!primed_reg)
                    begin
                        prev_next   = sample_ch.sample_in;
                        primed_next = 1'b1;
                    end
                    else if (!pos_below_one)
                    begin
                        // no result for this request
                        pos_next  = pos_reg - lir_pkg::FIX_ONE;
                        prev_next = sample_ch.sample_in;
                    end
                    else
                    begin
                        cur_next   = sample_ch.sample_in;
                        cnt_next   = '0;
                        pass_next  = 1'b0;
                        state_next = lir_pkg::ST_MUL;
                    end
                end
            end
            lir_pkg::ST_MUL:
            begin
                state_next = lir_pkg::ST_ADD;
            end
            lir_pkg::ST_ADD:
            begin
                out_data_next  = interp;
                out_last_next  = run_last;
                out_valid_next = 1'b1;
                pos_next       = pos_snap;
                cnt_next       = cnt_inc;
                state_next     = lir_pkg::ST_OUT;
            end
            lir_pkg::ST_OUT:
            begin
                if (result_ch.ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        if (!pass_reg)
                        begin
                            pos_next  = pos_reg - lir_pkg::FIX_ONE;
                            prev_next = cur_reg;
                        end
                        state_next = lir_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = lir_pkg::ST_MUL;
                    end
                end
            end
            default:
            begin
                state_next = lir_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lir_pkg::ST_IDLE;
            ratio_reg     <= lir_pkg::FIX_ONE[lir_pkg::RATIO_W-1:0];
            prev_reg      <= '0;
            pos_reg       <= '0;
            primed_reg    <= 1'b0;
            cnt_reg       <= '0;
            pass_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ratio_reg     <= ratio_next;
            prev_reg      <= prev_next;
            pos_reg       <= pos_next;
            primed_reg    <= primed_next;
            cnt_reg       <= cnt_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

endmodule

FILE: rtl/core/lir_checker.sv
// ----------------------------------------------------------------------------
// lir_checker
// Port-level checks of the resampler's channels over time.
// ----------------------------------------------------------------------------
module lir_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_sample,
    input logic        out_last
);

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_last))
        else $error("result dropped or changed while stalled");

    // the sequencer never takes a request while a result waits
    a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    // a result that ends the run frees the input next cycle
    a_run_end_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> in_ready)
        else $error("input not ready after end of run");

    // mid-run the next result is still being worked on
    a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> !in_ready && !out_valid)
        else $error("run ended early");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (sample_ch.ready),
    .out_valid  (result_ch.valid),
    .out_ready  (result_ch.ready),
    .out_sample (result_ch.sample_out),
    .out_last   (result_ch.run_end)
);

FILE: sim/linear_interp_resampler_tb.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler_tb
// Self-checking bench for the resampler. A directed table covers passthrough,
// priming, the run cap, position wrap and the ratio extremes. Random phases
// follow under several ratios and idle patterns. Results are compared with
// an in-bench interpolation predictor, or with a typed value in some rows.
// ----------------------------------------------------------------------------
module linear_interp_resampler_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RUN_MAX   = 8;
    localparam int unsigned DRAIN_GAP = 16;
    localparam int unsigned TAIL_GAP  = 50;
    localparam int unsigned LIMIT     = 200000;
    localparam int unsigned PH_ITEMS  = 12;
    localparam int unsigned PH_N      = 7;
    localparam int unsigned DIR_N     = 24;

    typedef struct packed {
        logic [lir_pkg::SMP_W-1:0] smp;
        logic                      last;
    } interp_res_t;

    typedef enum logic [1:0] {
        ROW_RATIO,
        ROW_SAMPLE
    } row_kind_t;

    // how a table row's results are known: predictor, none, or one typed value
    typedef enum logic [1:0] {
        WANT_MODEL,
        WANT_NONE,
        WANT_ONE
    } want_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [lir_pkg::SMP_W-1:0] value;
        want_t                     want;
        logic [lir_pkg::SMP_W-1:0] typed;
    } stim_row_t;

    localparam stim_row_t DIR_ROWS [DIR_N] = '{
        // ratio of one after reset: straight through, history untouched
        '{ROW_SAMPLE, 32'h0000_0000, WANT_ONE,   32'h0000_0000},
        '{ROW_SAMPLE, 32'h7fff_ffff, WANT_ONE,   32'h7fff_ffff},
        '{ROW_SAMPLE, 32'h8000_0000, WANT_ONE,   32'h8000_0000},
        '{ROW_SAMPLE, 32'hffff_ffff, WANT_ONE,   32'hffff_ffff},
        '{ROW_RATIO,  32'h0800_0000, WANT_NONE,  32'h0},
        // first real sample only primes the history
        '{ROW_SAMPLE, 32'h7fff_ffff, WANT_NONE,  32'h0},
        '{ROW_SAMPLE, 32'h8000_0000, WANT_MODEL, 32'h0},
        '{ROW_SAMPLE, 32'h0123_4567, WANT_MODEL, 32'h0},
        // lowest ratio in range: eight results per sample
        '{ROW_RATIO,  32'h0200_0000, WANT_NONE,  32'h0},
        '{ROW_SAMPLE, 32'hf000_0000, WANT_MODEL, 32'h0},
        // highest ratio: samples with no output, then position wrap and snap
        '{ROW_RATIO,  32'h7fff_ffff, WANT_NONE,  32'h0},
        '{ROW_SAMPLE, 32'h1000_0000, WANT_MODEL, 32'h0},
        '{ROW_SAMPLE, 32'ha5a5_a5a5, WANT_MODEL, 32'h0},
        '{ROW_SAMPLE, 32'h5a5a_5a5a, WANT_MODEL, 32'h0},
        '{ROW_SAMPLE, 32'h0000_0001, WANT_MODEL, 32'h0},
        '{ROW_SAMPLE, 32'hffff_fffe, WANT_MODEL, 32'h0},
        '{ROW_SAMPLE, 32'h0f0f_0f0f, WANT_MODEL, 32'h0},
        '{ROW_SAMPLE, 32'h8000_0001, WANT_MODEL, 32'h0},
        '{ROW_SAMPLE, 32'h1234_5678, WANT_MODEL, 32'h0},
        // zero ratio stops at the run cap
        '{ROW_RATIO,  32'h0000_0000, WANT_NONE,  32'h0},
        '{ROW_SAMPLE, 32'h3333_3333, WANT_MODEL, 32'h0},
        // a third: position lands just short of one and snaps
        '{ROW_RATIO,  32'h0555_5555, WANT_NONE,  32'h0},
        '{ROW_SAMPLE, 32'hc000_0000, WANT_MODEL, 32'h0},
        '{ROW_SAMPLE, 32'h4000_0000, WANT_MODEL, 32'h0}
    };

    localparam int unsigned PH_SRC_IDLE  [PH_N] = '{0, 46, 0, 10, 0, 46, 0};
    localparam int unsigned PH_SINK_IDLE [PH_N] = '{0, 0, 46, 10, 0, 0, 46};
    localparam int unsigned PH_HOLD      [PH_N] = '{0, 0, 0, 0, 400, 0, 0};

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [lir_pkg::RATIO_W-1:0] cfg_data;

    lir_smp_if smp_ch ();
    lir_res_if res_ch ();

    // predictor state
    logic [lir_pkg::RATIO_W-1:0] cur_ratio;
    logic [lir_pkg::SMP_W-1:0]   prev_smp;
    logic [lir_pkg::SMP_W-1:0]   cur_pos;
    logic                        primed;

    interp_res_t step_results [$];
    interp_res_t pending_results [$];

    int unsigned errors;
    int unsigned cycles;
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned hold_left;

    linear_interp_resampler #(
        .MAX_RUN (RUN_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (smp_ch),
        .result_ch (res_ch),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t ns  mismatch: %s", $time, msg);
    endtask

    // one input sample through the interpolator, results into step_results
    function automatic void interp_step(input logic [lir_pkg::SMP_W-1:0] s);
        logic [lir_pkg::SMP_W-1:0] y;
        logic [lir_pkg::SMP_W-1:0] diff;
        logic signed [63:0]        prod;
        int                        run_cap;
        int                        n;
        step_results.delete();
        run_cap = (RUN_MAX < lir_pkg::OUT_LIMIT) ? RUN_MAX : lir_pkg::OUT_LIMIT;
        n = 0;
        if ({1'b0, cur_ratio} == lir_pkg::FIX_ONE)
        begin
            step_results.push_back('{smp: s, last: 1'b1});
            return;
        end
        if (!primed)
        begin
            prev_smp = s;
            primed = 1'b1;
            return;
        end
        while (n < run_cap && $signed(cur_pos) < $signed(lir_pkg::FIX_ONE))
        begin
            if (cur_pos != '0)
            begin
                diff = s - prev_smp;
                prod = $signed({{32{diff[31]}}, diff})
                     * $signed({{32{cur_pos[31]}}, cur_pos});
                y = prev_smp
                  + prod[lir_pkg::FRAC_W+lir_pkg::SMP_W-1:lir_pkg::FRAC_W];
            end
            else
                y = prev_smp;
            step_results.push_back('{smp: y, last: 1'b0});
            n++;
            cur_pos = cur_pos + {1'b0, cur_ratio};
            if (((cur_pos + lir_pkg::SNAP_ADD) & lir_pkg::SNAP_TEST) == '0)
                cur_pos = (cur_pos + lir_pkg::SNAP_ADD) & ~lir_pkg::FRAC_MASK;
        end
        if (n > 0)
            step_results[n-1].last = 1'b1;
        cur_pos = cur_pos - lir_pkg::FIX_ONE;
        prev_smp = s;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_sample(input logic [lir_pkg::SMP_W-1:0] v, input want_t want,
                               input logic [lir_pkg::SMP_W-1:0] typed);
        while ($urandom_range(99) < src_idle_pct)
        begin
            smp_ch.valid <= 1'b0;
            @(negedge clk);
        end
        smp_ch.valid     <= 1'b1;
        smp_ch.sample_in <= v;
        @(posedge clk);
        while (!smp_ch.ready)
            @(posedge clk);
        interp_step(v);
        case (want)
            WANT_MODEL: foreach (step_results[k]) pending_results.push_back(step_results[k]);
            WANT_ONE:   pending_results.push_back('{smp: typed, last: 1'b1});
            default:    ;
        endcase
        @(negedge clk);
    endtask

    // idle the input and let every outstanding result drain
    task automatic settle();
        smp_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_ratio(input logic [lir_pkg::RATIO_W-1:0] v);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_ratio = v;
    endtask

    // result side, stall count for the long hold-off kept here
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        interp_res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result %h", res_ch.sample_out));
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.sample_out !== want.smp)
                    report_mismatch($sformatf("sample_out %h, want %h",
                                              res_ch.sample_out, want.smp));
                if (res_ch.run_end !== want.last)
                    report_mismatch($sformatf("run_end %b, want %b (sample %h)",
                                              res_ch.run_end, want.last, want.smp));
            end
        end
    end

    initial
    begin
        logic [lir_pkg::RATIO_W-1:0] ph_ratio [PH_N];
        logic [lir_pkg::SMP_W-1:0]   s;
        errors           = 0;
        cycles           = 0;
        src_idle_pct     = 0;
        sink_idle_pct    = 0;
        hold_left        = 0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_data         = '0;
        smp_ch.valid     = 1'b0;
        smp_ch.sample_in = '0;
        cur_ratio        = lir_pkg::FIX_ONE[lir_pkg::RATIO_W-1:0];
        prev_smp         = '0;
        cur_pos          = '0;
        primed           = 1'b0;
        s                = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_N; i++)
        begin
            if (DIR_ROWS[i].kind == ROW_RATIO)
                write_ratio(DIR_ROWS[i].value[lir_pkg::RATIO_W-1:0]);
            else
                send_sample(DIR_ROWS[i].value, DIR_ROWS[i].want, DIR_ROWS[i].typed);
        end

        ph_ratio = '{31'h0c00_0000, 31'h0200_0000, 31'h0, 31'h0555_5555,
                     31'h0200_0000, 31'h1000_0000, 31'h7fff_ffff};
        s = $urandom_range(32'h0200_0000, 32'h1fff_ffff);
        ph_ratio[2] = s[lir_pkg::RATIO_W-1:0];

        for (int p = 0; p < PH_N; p++)
        begin
            write_ratio(ph_ratio[p]);
            src_idle_pct  = PH_SRC_IDLE[p];
            sink_idle_pct = PH_SINK_IDLE[p];
            hold_left     = PH_HOLD[p];
            for (int i = 0; i < PH_ITEMS; i++)
            begin
                // mostly audio-like steps, some full-scale jumps
                if ($urandom_range(99) < 30)
                    s = $urandom;
                else
                    s = s + $urandom_range(0, 32'h01ff_ffff) - 32'h0100_0000;
                send_sample(s, WANT_MODEL, '0);
            end
        end

        settle();
        repeat (TAIL_GAP) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
